// File: rtl/cssl_pkg.sv
`default_nettype none

package cssl_pkg;

   localparam int ADDR_W      = 8;
   localparam int DATA_W      = 8;
   localparam int STORE_DEPTH = 256;
   localparam int OP_W        = 3;
   localparam int SLOT_W      = 3;
   localparam int INDEX_W     = 5;
   localparam int CFG_INDEX_W = 8;

   typedef logic [ADDR_W-1:0] addr_type;
   typedef logic [DATA_W-1:0] byte_type;
   typedef logic [OP_W-1:0]   op_type;

   localparam op_type OP_WRITE_PATTERN = 3'd0;
   localparam op_type OP_READ_SLOT     = 3'd1;
   localparam op_type OP_COPY_SLOT     = 3'd2;
   localparam op_type OP_READ_CONFIG   = 3'd3;
   localparam op_type OP_WRITE_CONFIG  = 3'd4;

   localparam byte_type HASH_SEED = 8'd33;

   typedef struct packed {
      logic     we;
      addr_type waddr;
      byte_type wdata;
      logic     re;
      addr_type raddr;
   } mem_req_type;

   typedef struct packed {
      byte_type data;
      logic     status;
      logic     last;
   } rsp_word_type;

endpackage

`default_nettype wire

// File: rtl/cssl_if.sv
`default_nettype none

interface cssl_req_if;
   import cssl_pkg::*;

   logic                   valid;
   logic                   ready;
   logic [OP_W-1:0]        operation;
   logic [SLOT_W-1:0]      slot;
   logic [SLOT_W-1:0]      dest_slot;
   logic [INDEX_W-1:0]     byte_index;
   logic [DATA_W-1:0]      data_in;
   logic [CFG_INDEX_W-1:0] config_index;

   modport source (output valid, operation, slot, dest_slot, byte_index, data_in,
                   config_index, input ready);
   modport sink   (input valid, operation, slot, dest_slot, byte_index, data_in,
                   config_index, output ready);
endinterface

interface cssl_rsp_if;
   import cssl_pkg::*;

   logic              valid;
   logic              ready;
   logic [DATA_W-1:0] data_out;
   logic              status;
   logic              last;

   modport source (output valid, data_out, status, last, input ready);
   modport sink   (input valid, data_out, status, last, output ready);
endinterface

`default_nettype wire

// File: rtl/cssl_store.sv
`default_nettype none

module cssl_store (
   input  logic                  clock,
   input  cssl_pkg::mem_req_type mem_req,
   output cssl_pkg::byte_type    rd_data
);
   import cssl_pkg::*;

   byte_type mem_ff [STORE_DEPTH];
   byte_type rd_data_ff;

   // write port and registered read port; read data holds between reads
   always_ff @(posedge clock) begin
      if (mem_req.we) begin
         mem_ff[mem_req.waddr] <= mem_req.wdata;
      end
      if (mem_req.re) begin
         rd_data_ff <= mem_ff[mem_req.raddr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: rtl/cssl_seq.sv
`default_nettype none

module cssl_seq #(
   parameter int PATTERN_BYTES = 31,
   parameter int SLOT_BYTES    = 32,
   parameter int CONFIG_TOP    = 255
) (
   input  logic                   clock,
   input  logic                   reset,
   cssl_req_if.sink               req_bus,
   input  logic                   out_free,
   output logic                   out_load,
   output cssl_pkg::rsp_word_type out_word,
   output cssl_pkg::mem_req_type  mem_req,
   input  cssl_pkg::byte_type     rd_data
);
   import cssl_pkg::*;

   localparam int CNT_W = $clog2(SLOT_BYTES + PATTERN_BYTES + 1);

   typedef enum logic [6:0] {
      S_CLEAR   = 7'b0000001,
      S_IDLE    = 7'b0000010,
      S_CSUM    = 7'b0000100,
      S_EMIT    = 7'b0001000,
      S_COPY_RD = 7'b0010000,
      S_COPY_WR = 7'b0100000,
      S_RESP    = 7'b1000000
   } state_type;

   state_type        state_ff, state_in;
   addr_type         clr_ff, clr_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             rdv_ff, rdv_in;
   logic [CNT_W-1:0] rdk_ff, rdk_in;
   byte_type         hash_ff, hash_in;
   addr_type         base_ff, base_in;
   addr_type         dbase_ff, dbase_in;
   logic             csum_wr_ff, csum_wr_in;
   logic             err_ff, err_in;
   logic             sel_rd_ff, sel_rd_in;

   logic [11:0] src_prod;
   logic [11:0] dst_prod;
   addr_type    req_base;
   addr_type    req_dbase;
   addr_type    cfg_addr;
   logic        accept;

   assign src_prod  = 12'(req_bus.slot) * 12'(SLOT_BYTES);
   assign dst_prod  = 12'(req_bus.dest_slot) * 12'(SLOT_BYTES);
   assign req_base  = src_prod[ADDR_W-1:0];
   assign req_dbase = dst_prod[ADDR_W-1:0];
   assign cfg_addr  = ADDR_W'(CONFIG_TOP) - req_bus.config_index;

   assign req_bus.ready = (state_ff == S_IDLE);
   assign accept        = req_bus.valid && req_bus.ready;

   always_comb begin
      state_in   = state_ff;
      clr_in     = clr_ff;
      cnt_in     = cnt_ff;
      rdv_in     = 1'b0;
      rdk_in     = cnt_ff;
      hash_in    = hash_ff;
      base_in    = base_ff;
      dbase_in   = dbase_ff;
      csum_wr_in = csum_wr_ff;
      err_in     = err_ff;
      sel_rd_in  = sel_rd_ff;
      mem_req    = '0;
      out_load   = 1'b0;
      out_word   = '0;

      unique case (state_ff)
         S_CLEAR: begin
            mem_req.we    = 1'b1;
            mem_req.waddr = clr_ff;
            mem_req.wdata = '0;
            clr_in        = clr_ff + 1'b1;
            if (clr_ff == ADDR_W'(STORE_DEPTH - 1)) begin
               state_in = S_IDLE;
            end
         end

         S_IDLE: begin
            if (accept) begin
               cnt_in     = '0;
               hash_in    = HASH_SEED;
               base_in    = req_base;
               dbase_in   = req_dbase;
               csum_wr_in = 1'b0;
               err_in     = 1'b0;
               sel_rd_in  = 1'b0;
               state_in   = S_RESP;
               unique case (req_bus.operation)
                  OP_WRITE_PATTERN: begin
                     if (int'(req_bus.byte_index) < PATTERN_BYTES) begin
                        mem_req.we    = 1'b1;
                        mem_req.waddr = req_base + ADDR_W'(req_bus.byte_index);
                        mem_req.wdata = req_bus.data_in;
                        if (int'(req_bus.byte_index) == PATTERN_BYTES - 1) begin
                           csum_wr_in = 1'b1;
                           state_in   = S_CSUM;
                        end
                     end
                  end
                  OP_READ_SLOT: begin
                     state_in = S_CSUM;
                  end
                  OP_COPY_SLOT: begin
                     state_in = S_COPY_RD;
                  end
                  OP_READ_CONFIG: begin
                     mem_req.re    = 1'b1;
                     mem_req.raddr = cfg_addr;
                     sel_rd_in     = 1'b1;
                  end
                  OP_WRITE_CONFIG: begin
                     mem_req.we    = 1'b1;
                     mem_req.waddr = cfg_addr;
                     mem_req.wdata = req_bus.data_in;
                  end
                  default: begin
                     // unknown operation: acknowledge only
                  end
               endcase
            end
         end

         S_CSUM: begin
            // issue data reads and the stored checksum read, fold as they return, then write or check the checksum
            if (cnt_ff <= CNT_W'(PATTERN_BYTES)) begin
               mem_req.re    = 1'b1;
               mem_req.raddr = base_ff + ADDR_W'(cnt_ff);
               rdv_in        = 1'b1;
               cnt_in        = cnt_ff + 1'b1;
            end
            if (rdv_ff) begin
               if (rdk_ff < CNT_W'(PATTERN_BYTES)) begin
                  hash_in = {hash_ff[2:0], 5'b0} + hash_ff + rd_data;
               end else if (csum_wr_ff) begin
                  mem_req.we    = 1'b1;
                  mem_req.waddr = base_ff + ADDR_W'(PATTERN_BYTES);
                  mem_req.wdata = hash_ff;
                  state_in      = S_RESP;
               end else if (rd_data == hash_ff) begin
                  mem_req.re    = 1'b1;
                  mem_req.raddr = base_ff;
                  cnt_in        = '0;
                  state_in      = S_EMIT;
               end else begin
                  err_in   = 1'b1;
                  state_in = S_RESP;
               end
            end
         end

         S_EMIT: begin
            if (out_free) begin
               out_load        = 1'b1;
               out_word.data   = rd_data;
               out_word.status = 1'b0;
               out_word.last   = (cnt_ff == CNT_W'(PATTERN_BYTES - 1));
               if (out_word.last) begin
                  state_in = S_IDLE;
               end else begin
                  mem_req.re    = 1'b1;
                  mem_req.raddr = base_ff + ADDR_W'(cnt_ff) + 1'b1;
                  cnt_in        = cnt_ff + 1'b1;
               end
            end
         end

         S_COPY_RD: begin
            mem_req.re    = 1'b1;
            mem_req.raddr = base_ff + ADDR_W'(cnt_ff);
            state_in      = S_COPY_WR;
         end

         S_COPY_WR: begin
            mem_req.we    = 1'b1;
            mem_req.waddr = dbase_ff + ADDR_W'(cnt_ff);
            mem_req.wdata = rd_data;
            cnt_in        = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(SLOT_BYTES - 1)) begin
               state_in = S_RESP;
            end else begin
               state_in = S_COPY_RD;
            end
         end

         S_RESP: begin
            if (out_free) begin
               out_load        = 1'b1;
               out_word.data   = sel_rd_ff ? rd_data : '0;
               out_word.status = err_ff;
               out_word.last   = 1'b1;
               state_in        = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_ff   <= '0;
         rdv_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         rdv_ff   <= rdv_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff     <= cnt_in;
      rdk_ff     <= rdk_in;
      hash_ff    <= hash_in;
      base_ff    <= base_in;
      dbase_ff   <= dbase_in;
      csum_wr_ff <= csum_wr_in;
      err_ff     <= err_in;
      sel_rd_ff  <= sel_rd_in;
   end

endmodule

`default_nettype wire

// File: rtl/checksummed_slot_store_top.sv
`default_nettype none

// Checksummed slot store: a 256-byte store split into slots of SLOT_BYTES
// bytes, each slot holding PATTERN_BYTES data bytes and one checksum byte
// (seed 33, then hash*33+byte per data byte, modulo 256). After reset the
// block zeroes the store, one byte a cycle, and takes no word on req_bus
// until that pass ends. One request word is worked at a time; the store has
// a single, registered read port. A pattern byte write or config write
// returns one acknowledge word; a write of the final pattern index also
// walks the slot and stores its checksum first. A config read returns its
// byte from the store in time for the output register. A slot read walks
// the slot to check the checksum and then emits one data word per cycle
// while the output register is free; a checksum mismatch ends after the
// walk with one error word. A copy reads and then writes each byte in turn.
// A result waits in an output register, so a stalled rsp_bus holds the
// sequencer but does not lose the next request.
module checksummed_slot_store_top #(
   parameter int PATTERN_BYTES = 31,
   parameter int SLOT_BYTES    = 32,
   parameter int CONFIG_TOP    = 255
) (
   input  logic       clock,
   input  logic       reset,
   cssl_req_if.sink   req_bus,
   cssl_rsp_if.source rsp_bus
);
   import cssl_pkg::*;

   mem_req_type  mem_req;
   byte_type     rd_data;
   rsp_word_type out_word;
   logic         out_load;
   logic         out_free;

   logic         rsp_valid_ff, rsp_valid_in;
   rsp_word_type rsp_word_ff, rsp_word_in;

   // sequencer: decodes the request and walks the store
   cssl_seq #(
      .PATTERN_BYTES (PATTERN_BYTES),
      .SLOT_BYTES    (SLOT_BYTES),
      .CONFIG_TOP    (CONFIG_TOP)
   ) u_seq (
      .clock    (clock),
      .reset    (reset),
      .req_bus  (req_bus),
      .out_free (out_free),
      .out_load (out_load),
      .out_word (out_word),
      .mem_req  (mem_req),
      .rd_data  (rd_data)
   );

   // byte store: one write and one registered read per cycle
   cssl_store u_store (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

   // output register: accept a new word when empty or draining this cycle
   assign out_free     = !rsp_valid_ff || rsp_bus.ready;
   assign rsp_valid_in = out_load || (rsp_valid_ff && !rsp_bus.ready);
   assign rsp_word_in  = out_load ? out_word : rsp_word_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_bus.valid    = rsp_valid_ff;
   assign rsp_bus.data_out = rsp_word_ff.data;
   assign rsp_bus.status   = rsp_word_ff.status;
   assign rsp_bus.last     = rsp_word_ff.last;

   // never overwrite a word that is still waiting
   a_no_overrun : assert property (@(posedge clock) disable iff (reset)
      out_load |-> out_free)
      else $error("result loaded while output register is held");

   // the store is never read and written at one address in the same cycle
   a_no_rw_clash : assert property (@(posedge clock) disable iff (reset)
      (mem_req.we && mem_req.re) |-> (mem_req.waddr != mem_req.raddr))
      else $error("read and write hit the same store address");

   // a checksum error is always a single, final word
   a_err_last : assert property (@(posedge clock) disable iff (reset)
      (out_load && out_word.status) |-> out_word.last)
      else $error("error word without last marker");

   // mid-slot words keep the block busy
   a_busy_mid_read : assert property (@(posedge clock) disable iff (reset)
      (out_load && !out_word.last) |=> !req_bus.ready)
      else $error("request taken in the middle of a slot read");

endmodule

`default_nettype wire

// File: test/tb.sv
`default_nettype none

module tb;
   import cssl_pkg::*;

   // Geometry of the block under test; passed to the instance below.
   localparam int PATTERN_BYTES = 31;
   localparam int SLOT_BYTES    = 32;
   localparam int CONFIG_TOP    = 255;

   localparam int CLOCK_HALF    = 4;
   localparam int RESET_CYCLES  = 6;
   // The slowest legal run is a few hundred items, each a slot read of 31 words,
   // each word held off by a long receiver stall. Take that several times over.
   localparam int LIMIT_CYCLES  = 900_000;
   // Every word causes a result, so the drain pause covers the longest operation.
   localparam int DRAIN_CYCLES  = 2 * PATTERN_BYTES + 2 * SLOT_BYTES + 16;
   localparam int RANDOM_ITEMS  = 330;

   logic clock;
   logic reset;

   cssl_req_if req_bus ();
   cssl_rsp_if rsp_bus ();

   checksummed_slot_store_top #(
      .PATTERN_BYTES (PATTERN_BYTES),
      .SLOT_BYTES    (SLOT_BYTES),
      .CONFIG_TOP    (CONFIG_TOP)
   ) dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   // Own copy of the store, and the result words it says must come back, oldest first.
   byte_type     store_image [STORE_DEPTH];
   rsp_word_type rsp_due [$];
   rsp_word_type rsp_want;

   int fail_count  = 0;
   int cycle_count = 0;
   int idle_pct    = 0;   // chance, per cycle, that the sender holds a word back
   int stall_pct   = 0;   // chance, per cycle, that the receiver drops ready

   // ------------------------------------------------------------------
   // Clock, and a watchdog that ends a hung run.
   // ------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #CLOCK_HALF clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("%0t: watchdog expired with %0d result words outstanding",
                  $realtime, rsp_due.size());
         $display("== FAIL ==");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // Predictor: mirror of the store and the words each operation returns.
   // ------------------------------------------------------------------
   function automatic addr_type slot_base_of(logic [SLOT_W-1:0] slot);
      return addr_type'(int'(slot) * SLOT_BYTES);
   endfunction

   // Seed 33, then hash*33 + byte for each data byte; the byte width drops the carry.
   function automatic byte_type slot_hash(addr_type base);
      byte_type h;
      h = HASH_SEED;
      for (int k = 0; k < PATTERN_BYTES; k++)
         h = byte_type'(h * 8'd33 + store_image[addr_type'(base + k)]);
      return h;
   endfunction

   function automatic void queue_word(byte_type data, logic status, logic last);
      rsp_word_type w;
      w.data   = data;
      w.status = status;
      w.last   = last;
      rsp_due.push_back(w);
   endfunction

   // Apply one accepted request word to the mirror and queue its results.
   function automatic void apply_store_op(op_type op, logic [SLOT_W-1:0] slot,
                                          logic [SLOT_W-1:0] dest,
                                          logic [INDEX_W-1:0] idx, byte_type data,
                                          logic [CFG_INDEX_W-1:0] cidx);
      addr_type base;
      addr_type dbase;
      addr_type caddr;
      base  = slot_base_of(slot);
      dbase = slot_base_of(dest);
      caddr = addr_type'(CONFIG_TOP - int'(cidx));
      case (op)
         OP_WRITE_PATTERN: begin
            // An index past the data area is acknowledged and otherwise dropped.
            if (idx < PATTERN_BYTES) begin
               store_image[addr_type'(base + idx)] = data;
               if (idx == PATTERN_BYTES - 1)
                  store_image[addr_type'(base + PATTERN_BYTES)] = slot_hash(base);
            end
            queue_word('0, 1'b0, 1'b1);
         end
         OP_READ_SLOT: begin
            if (store_image[addr_type'(base + PATTERN_BYTES)] != slot_hash(base)) begin
               queue_word('0, 1'b1, 1'b1);
            end else begin
               for (int k = 0; k < PATTERN_BYTES; k++)
                  queue_word(store_image[addr_type'(base + k)], 1'b0,
                             k == PATTERN_BYTES - 1);
            end
         end
         OP_COPY_SLOT: begin
            // Ascending, byte by byte, so overlapping copies smear as the block does.
            for (int k = 0; k < SLOT_BYTES; k++)
               store_image[addr_type'(dbase + k)] = store_image[addr_type'(base + k)];
            queue_word('0, 1'b0, 1'b1);
         end
         OP_READ_CONFIG: queue_word(store_image[caddr], 1'b0, 1'b1);
         OP_WRITE_CONFIG: begin
            store_image[caddr] = data;
            queue_word('0, 1'b0, 1'b1);
         end
         default: queue_word('0, 1'b0, 1'b1);
      endcase
   endfunction

   // ------------------------------------------------------------------
   // Request side: drive at the falling edge, hold until the rising edge
   // that sees ready, then predict.
   // ------------------------------------------------------------------
   task automatic send_word(op_type op, int slot, int dest, int idx, int data, int cidx);
      @(negedge clock);
      // Hold the channel idle for a random number of cycles.
      while ($urandom_range(99) < idle_pct) begin
         req_bus.valid = 1'b0;
         @(negedge clock);
      end
      req_bus.operation    = op;
      req_bus.slot         = slot[SLOT_W-1:0];
      req_bus.dest_slot    = dest[SLOT_W-1:0];
      req_bus.byte_index   = idx[INDEX_W-1:0];
      req_bus.data_in      = data[DATA_W-1:0];
      req_bus.config_index = cidx[CFG_INDEX_W-1:0];
      req_bus.valid        = 1'b1;
      do
         @(posedge clock);
      while (!req_bus.ready);
      apply_store_op(op, req_bus.slot, req_bus.dest_slot, req_bus.byte_index,
                     req_bus.data_in, req_bus.config_index);
   endtask

   // Shorthand for fields an operation ignores: fill them with noise.
   function automatic int noise();
      return $urandom;
   endfunction

   // ------------------------------------------------------------------
   // Result side: stall at random, check each accepted word in order.
   // ------------------------------------------------------------------
   always @(negedge clock)
      rsp_bus.ready = ($urandom_range(99) >= stall_pct);

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (rsp_due.size() == 0) begin
            $display("%0t: unexpected word data=%02h status=%0d last=%0d", $realtime,
                     rsp_bus.data_out, rsp_bus.status, rsp_bus.last);
            fail_count++;
         end else begin
            rsp_want = rsp_due.pop_front();
            if (rsp_bus.data_out !== rsp_want.data) begin
               $display("%0t: data_out expected %02h actual %02h", $realtime,
                        rsp_want.data, rsp_bus.data_out);
               fail_count++;
            end
            if (rsp_bus.status !== rsp_want.status) begin
               $display("%0t: status expected %0d actual %0d", $realtime,
                        rsp_want.status, rsp_bus.status);
               fail_count++;
            end
            if (rsp_bus.last !== rsp_want.last) begin
               $display("%0t: last expected %0d actual %0d", $realtime,
                        rsp_want.last, rsp_bus.last);
               fail_count++;
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   // The store comes out of reset all zero, so slot 0 holds a stale checksum.
   task automatic test_after_reset();
      send_word(OP_READ_SLOT, 0, noise(), noise(), noise(), noise());
      send_word(OP_READ_CONFIG, noise(), noise(), noise(), noise(), 0);
   endtask

   // Writing the final data index seals the slot with a fresh checksum.
   task automatic test_pattern_write();
      send_word(OP_WRITE_PATTERN, 0, 7, 0, 8'hFF, 8'hFF);
      send_word(OP_WRITE_PATTERN, 0, 0, PATTERN_BYTES - 1, 8'h00, 0);
      send_word(OP_READ_SLOT, 0, noise(), noise(), noise(), noise());
      // Index past the data area: acknowledge only.
      send_word(OP_WRITE_PATTERN, 0, noise(), 2**INDEX_W - 1, 8'h5A, noise());
      send_word(OP_WRITE_PATTERN, 2, 7, 15, 8'h3C, 255);
      send_word(OP_WRITE_PATTERN, 7, 0, PATTERN_BYTES - 1, 8'h80, 0);
      send_word(OP_READ_SLOT, 7, noise(), noise(), noise(), noise());
   endtask

   // Whole-slot copies, including a copy onto itself.
   task automatic test_copy();
      send_word(OP_COPY_SLOT, 0, 7, noise(), noise(), noise());
      send_word(OP_READ_SLOT, 7, noise(), noise(), noise(), noise());
      send_word(OP_COPY_SLOT, 3, 3, noise(), noise(), noise());
      send_word(OP_READ_SLOT, 3, noise(), noise(), noise(), noise());
   endtask

   // Config bytes count down from the top; index 0 lands on slot 7's checksum.
   task automatic test_config();
      send_word(OP_WRITE_CONFIG, noise(), noise(), noise(), 8'h11, 0);
      send_word(OP_READ_SLOT, 7, noise(), noise(), noise(), noise());
      send_word(OP_READ_CONFIG, noise(), noise(), noise(), noise(), 0);
      send_word(OP_WRITE_CONFIG, noise(), noise(), noise(), 8'hFF, 255);
      send_word(OP_READ_CONFIG, noise(), noise(), noise(), noise(), 255);
      send_word(OP_READ_SLOT, 0, noise(), noise(), noise(), noise());
   endtask

   // Unused operation codes: acknowledge, touch nothing.
   task automatic test_unknown_op();
      for (int k = OP_WRITE_CONFIG + 1; k < 2**OP_W; k++)
         send_word(op_type'(k), noise(), noise(), noise(), noise(), noise());
      send_word(OP_READ_SLOT, 7, noise(), noise(), noise(), noise());
   endtask

   // Mostly well-formed traffic: fill bytes, seal, read back, copy, config.
   task automatic test_random_traffic(int count, int idle, int stall);
      int sent;
      int pick;
      int slot;
      int dest;
      sent      = 0;
      idle_pct  = idle;
      stall_pct = stall;
      while (sent < count) begin
         pick = $urandom_range(99);
         slot = $urandom_range(2**SLOT_W - 1);
         dest = $urandom_range(2**SLOT_W - 1);
         if (pick < 35) begin
            send_word(OP_WRITE_PATTERN, slot, noise(),
                      $urandom_range(PATTERN_BYTES - 1), noise(), noise());
            sent++;
         end else if (pick < 50) begin
            // Seal a slot and read it straight back.
            send_word(OP_WRITE_PATTERN, slot, noise(), PATTERN_BYTES - 1, noise(), noise());
            send_word(OP_READ_SLOT, slot, noise(), noise(), noise(), noise());
            sent += 2;
         end else if (pick < 60) begin
            send_word(OP_READ_SLOT, slot, noise(), noise(), noise(), noise());
            sent++;
         end else if (pick < 70) begin
            send_word(OP_COPY_SLOT, slot, dest, noise(), noise(), noise());
            send_word(OP_READ_SLOT, dest, noise(), noise(), noise(), noise());
            sent += 2;
         end else if (pick < 78) begin
            send_word(OP_WRITE_CONFIG, noise(), noise(), noise(), noise(), noise());
            sent++;
         end else if (pick < 86) begin
            send_word(OP_READ_CONFIG, noise(), noise(), noise(), noise(), noise());
            sent++;
         end else if (pick < 90) begin
            send_word(OP_WRITE_PATTERN, slot, noise(),
                      $urandom_range(2**INDEX_W - 1, PATTERN_BYTES), noise(), noise());
            sent++;
         end else if (pick < 94) begin
            send_word(op_type'($urandom_range(2**OP_W - 1, OP_WRITE_CONFIG + 1)),
                      noise(), noise(), noise(), noise(), noise());
            sent++;
         end else begin
            // Pure noise on every field.
            send_word(op_type'($urandom), noise(), noise(), noise(), noise(), noise());
            sent++;
         end
      end
   endtask

   // ------------------------------------------------------------------
   // Sequence
   // ------------------------------------------------------------------
   initial begin
      reset                = 1'b1;
      req_bus.valid        = 1'b0;
      req_bus.operation    = OP_WRITE_PATTERN;
      req_bus.slot         = '0;
      req_bus.dest_slot    = '0;
      req_bus.byte_index   = '0;
      req_bus.data_in      = '0;
      req_bus.config_index = '0;
      rsp_bus.ready        = 1'b0;
      for (int k = 0; k < STORE_DEPTH; k++)
         store_image[k] = '0;

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed part runs with no idling; the block's clearing pass holds ready low.
      test_after_reset();
      test_pattern_write();
      test_copy();
      test_config();
      test_unknown_op();

      // Random part, one phase per idling pattern.
      test_random_traffic(RANDOM_ITEMS / 4, 0, 0);
      test_random_traffic(RANDOM_ITEMS / 4, 66, 0);
      test_random_traffic(RANDOM_ITEMS / 4, 0, 66);
      test_random_traffic(RANDOM_ITEMS / 4, 29, 29);

      // Drop valid, drain the expected words, then give the block time to misbehave.
      @(negedge clock);
      req_bus.valid = 1'b0;
      while (rsp_due.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (fail_count == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule

`default_nettype wire

// File: files.f
rtl/cssl_pkg.sv
rtl/cssl_if.sv
rtl/cssl_store.sv
rtl/cssl_seq.sv
rtl/checksummed_slot_store_top.sv
test/tb.sv
